[rtl/ffba_pkg.sv]
// Package: payload types, status codes and request codes of the block allocator.
package ffba_pkg;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_NOSPACE = 3'd2;
    localparam logic [2:0] ST_NULL    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [16:0] req_size;
        logic [15:0] release_addr;
    } ffba_req_t;

    typedef struct packed {
        logic [15:0] grant_addr;
        logic [2:0]  status;
    } ffba_rsp_t;

    // Classified command handed from the front end to the engine.
    typedef struct packed {
        logic        is_release;
        logic        done;        // answered by the front end, no table work
        logic [2:0]  status;
        logic [17:0] size;        // rounded allocate size, one bit wider than the request
        logic [15:0] addr;        // release data address
    } ffba_cmd_t;

endpackage

[rtl/ffba_front.sv]
// Front end: accepts requests, classifies them and queues them for the engine.
module ffba_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ffba_pkg::ffba_req_t s_data,
    output logic               q_valid,
    input  logic               q_ready,
    output ffba_pkg::ffba_cmd_t q_cmd
);
    import ffba_pkg::*;

    ffba_cmd_t   fifo_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    ffba_cmd_t   cmd;
    logic [17:0] rsum;
    logic        push, pop;

    always_comb begin
        rsum = {1'b0, s_data.req_size} + 18'd7;
        cmd.is_release = (s_data.req_type == REQ_RELEASE);
        cmd.size       = {rsum[17:3], 3'b000};
        cmd.addr       = s_data.release_addr;
        cmd.done       = 1'b0;
        cmd.status     = ST_OK;
        if (cmd.is_release) begin
            if (s_data.release_addr == 16'd0) begin
                cmd.done   = 1'b1;
                cmd.status = ST_NULL;
            end
        end else if (s_data.req_size == 17'd0) begin
            cmd.done   = 1'b1;
            cmd.status = ST_ZERO;
        end
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = fifo_reg[rp_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) fifo_reg[wp_reg] <= cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !pop)
        else $error("queue read while empty");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop && cnt_reg != 2'd2) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count lost a push");
`endif
endmodule

[rtl/ffba_engine.sv]
// Engine: walks the block table, splits, appends, frees and merges entries.
module ffba_engine #(
    parameter int HEAP_BYTES   = 65536,
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16,
    parameter int MIN_SPLIT    = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [16:0]        heap_limit,
    input  logic               q_valid,
    output logic               q_ready,
    input  ffba_pkg::ffba_cmd_t q_cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output ffba_pkg::ffba_rsp_t m_data
);
    import ffba_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    // At least 17 bits so that the widest rounded request still compares whole.
    localparam int AW = ($clog2(HEAP_BYTES + 1) > 17) ? $clog2(HEAP_BYTES + 1) : 17;
    localparam logic [AW-1:0] HDR = AW'(HEADER_BYTES);
    localparam logic [AW:0]   SPL = (AW+1)'(HEADER_BYTES + MIN_SPLIT);
    localparam logic [AW:0]   HBY = (AW+1)'(HEAP_BYTES);
    localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCKS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_SHU   = 4'd3;  // shift up, read k-1
    localparam logic [3:0] S_SHUW  = 4'd4;  // shift up, write k
    localparam logic [3:0] S_INS   = 4'd5;
    localparam logic [3:0] S_RDN   = 4'd6;  // read next entry
    localparam logic [3:0] S_NXT   = 4'd7;
    localparam logic [3:0] S_SHD   = 4'd8;  // shift down, read k+1
    localparam logic [3:0] S_SHDW  = 4'd9;
    localparam logic [3:0] S_RDP   = 4'd10; // read previous entry
    localparam logic [3:0] S_PRV   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    // Table memory: start, bytes and free flag in one word.
    localparam int EW = 2 * AW + 1;
    logic [EW-1:0] mem [MAX_BLOCKS];
    logic [EW-1:0] rd_reg;
    logic [IW-1:0] raddr;
    logic          we;
    logic [IW-1:0] waddr;
    logic [EW-1:0] wdata;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    logic [AW-1:0] rd_start, rd_bytes;
    logic          rd_free;
    assign rd_start = rd_reg[EW-1 -: AW];
    assign rd_bytes = rd_reg[AW:1];
    assign rd_free  = rd_reg[0];

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW:0]   top_reg, top_next;
    logic [CW-1:0] i_reg, i_next, k_reg, k_next;
    ffba_cmd_t     cmd_reg, cmd_next;
    logic [AW-1:0] cur_start_reg, cur_start_next, cur_bytes_reg, cur_bytes_next;
    logic [EW-1:0] ins_reg, ins_next;
    logic          mode_reg, mode_next;   // shift-down purpose: 0 next merge, 1 prev
    logic [15:0]   gaddr_reg, gaddr_next;
    logic [2:0]    gst_reg, gst_next;
    logic          ov_reg, ov_next;

    logic [AW:0]   limit, need, size_w;
    logic [15:0]   cmp_addr;

    always_comb begin
        limit    = ({1'b0, heap_limit} > (AW+1)'(HEAP_BYTES)) ? HBY :
                   (AW+1)'(heap_limit);
        size_w   = (AW+1)'(cmd_reg.size);
        need     = top_reg + (AW+1)'(HEADER_BYTES) + size_w;
        cmp_addr = 16'(rd_start + HDR);
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        cmd_next       = cmd_reg;
        cur_start_next = cur_start_reg;
        cur_bytes_next = cur_bytes_reg;
        ins_next       = ins_reg;
        mode_next      = mode_reg;
        gaddr_next     = gaddr_reg;
        gst_next       = gst_reg;
        ov_next        = ov_reg;
        raddr          = i_reg[IW-1:0];
        we             = 1'b0;
        waddr          = i_reg[IW-1:0];
        wdata          = rd_reg;
        q_ready        = 1'b0;
        if (ov_reg && m_ready) ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                q_ready = !ov_reg || m_ready;
                if (q_valid && q_ready) begin
                    cmd_next   = q_cmd;
                    i_next     = '0;
                    gaddr_next = 16'd0;
                    gst_next   = q_cmd.status;
                    if (q_cmd.done) begin
                        ov_next = 1'b1;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                if (i_reg >= count_reg) begin
                    if (cmd_reg.is_release) begin
                        gst_next   = ST_UNKNOWN;
                        state_next = S_OUT;
                    end else if (count_reg >= MAXB || need > limit) begin
                        gst_next   = ST_NOSPACE;
                        state_next = S_OUT;
                    end else begin
                        we         = 1'b1;
                        waddr      = count_reg[IW-1:0];
                        wdata      = {top_reg[AW-1:0], size_w[AW-1:0], 1'b0};
                        count_next = count_reg + 1'b1;
                        gaddr_next = 16'(top_reg + (AW+1)'(HEADER_BYTES));
                        gst_next   = ST_OK;
                        top_next   = need;
                        state_next = S_OUT;
                    end
                end else begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                cur_start_next = rd_start;
                cur_bytes_next = rd_bytes;
                if (cmd_reg.is_release) begin
                    if (cmp_addr == cmd_reg.addr) begin
                        if (rd_free) begin
                            gst_next   = ST_UNKNOWN;
                            state_next = S_OUT;
                        end else begin
                            we         = 1'b1;
                            wdata      = {rd_start, rd_bytes, 1'b1};
                            gst_next   = ST_OK;
                            raddr      = IW'(i_reg + 1'b1);
                            state_next = S_RDN;
                        end
                    end else begin
                        i_next     = i_reg + 1'b1;
                        raddr      = IW'(i_reg + 1'b1);
                        state_next = S_RD;
                    end
                end else if (rd_free && (AW+1)'(rd_bytes) >= size_w) begin
                    gst_next   = ST_OK;
                    gaddr_next = 16'(rd_start + HDR);
                    we         = 1'b1;
                    if ((AW+1)'(rd_bytes) >= size_w + SPL && count_reg < MAXB) begin
                        wdata    = {rd_start, size_w[AW-1:0], 1'b0};
                        ins_next = {AW'(rd_start + HDR + size_w[AW-1:0]),
                                    AW'(rd_bytes - size_w[AW-1:0] - HDR), 1'b1};
                        k_next   = count_reg;
                        raddr    = IW'(count_reg - 1'b1);
                        state_next = S_SHU;
                    end else begin
                        wdata      = {rd_start, rd_bytes, 1'b0};
                        state_next = S_OUT;
                    end
                end else begin
                    i_next     = i_reg + 1'b1;
                    raddr      = IW'(i_reg + 1'b1);
                    state_next = S_RD;
                end
            end
            S_SHU: begin
                // Move entries i+1..count-1 up by one, top first.
                if (k_reg > i_reg + 1'b1) begin
                    raddr      = IW'(k_reg - 1'b1);
                    state_next = S_SHUW;
                end else begin
                    state_next = S_INS;
                end
            end
            S_SHUW: begin
                we         = 1'b1;
                waddr      = k_reg[IW-1:0];
                wdata      = rd_reg;
                k_next     = k_reg - 1'b1;
                state_next = S_SHU;
            end
            S_INS: begin
                we         = 1'b1;
                waddr      = IW'(i_reg + 1'b1);
                wdata      = ins_reg;
                count_next = count_reg + 1'b1;
                state_next = S_OUT;
            end
            S_RDN: begin
                raddr = IW'(i_reg + 1'b1);
                if (i_reg + 1'b1 < count_reg) begin
                    state_next = S_NXT;
                end else begin
                    state_next = S_RDP;
                end
            end
            S_NXT: begin
                if (rd_free) begin
                    cur_bytes_next = AW'(cur_bytes_reg + HDR + rd_bytes);
                    we    = 1'b1;
                    wdata = {cur_start_reg, AW'(cur_bytes_reg + HDR + rd_bytes), 1'b1};
                    k_next     = i_reg + 1'b1;
                    mode_next  = 1'b0;
                    state_next = S_SHD;
                end else begin
                    state_next = S_RDP;
                end
            end
            S_SHD: begin
                // Remove entry k by moving the entries above it down.
                if (k_reg + 1'b1 < count_reg) begin
                    raddr      = IW'(k_reg + 1'b1);
                    state_next = S_SHDW;
                end else begin
                    count_next = count_reg - 1'b1;
                    state_next = mode_reg ? S_OUT : S_RDP;
                end
            end
            S_SHDW: begin
                we         = 1'b1;
                waddr      = k_reg[IW-1:0];
                wdata      = rd_reg;
                k_next     = k_reg + 1'b1;
                state_next = S_SHD;
            end
            S_RDP: begin
                if (i_reg != '0) begin
                    raddr      = IW'(i_reg - 1'b1);
                    state_next = S_PRV;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_PRV: begin
                if (rd_free) begin
                    we    = 1'b1;
                    waddr = IW'(i_reg - 1'b1);
                    wdata = {rd_start, AW'(rd_bytes + HDR + cur_bytes_reg), 1'b1};
                    k_next     = i_reg;
                    mode_next  = 1'b1;
                    state_next = S_SHD;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!ov_reg || m_ready) begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            top_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            top_reg   <= top_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg         <= i_next;
        k_reg         <= k_next;
        cmd_reg       <= cmd_next;
        cur_start_reg <= cur_start_next;
        cur_bytes_reg <= cur_bytes_next;
        ins_reg       <= ins_next;
        mode_reg      <= mode_next;
        gaddr_reg     <= gaddr_next;
        gst_reg       <= gst_next;
    end

    assign m_valid           = ov_reg;
    assign m_data.grant_addr = gaddr_reg;
    assign m_data.status     = gst_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAXB)
        else $error("block count beyond table depth");
    a_top_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg <= HBY)
        else $error("heap top beyond heap size");
    a_release_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && cmd_reg.is_release) |-> (gaddr_reg == 16'd0))
        else $error("release returned an address");
`endif
endmodule

[rtl/first_fit_block_allocator_unit.sv]
// Top level of the first-fit block allocator with splitting and coalescing.
// Each request transaction yields exactly one result transaction, in order.
// Zero-size allocates and null releases are answered by the front end; all
// other requests walk the block table held in a memory with one read and one
// write port, and entries are moved when a split inserts or a merge removes a
// table entry. A two-entry queue separates the front end from the engine, and
// the result sits in an output register so a new request transaction can be
// taken while a result waits.
// The heap_limit register is written with cfg_we and must only change while
// the block is idle.
module first_fit_block_allocator_unit #(
    parameter int HEAP_BYTES   = 65536,
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16,
    parameter int MIN_SPLIT    = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [16:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  ffba_pkg::ffba_req_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ffba_pkg::ffba_rsp_t m_data
);
    import ffba_pkg::*;

    logic [16:0] heap_limit_reg;
    logic        q_valid, q_ready;
    ffba_cmd_t   q_cmd;

    // Configuration register; reset allows the whole heap.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_limit_reg <= 17'h10000;
        end else if (cfg_we) begin
            heap_limit_reg <= cfg_wdata;
        end
    end

    ffba_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd)
    );

    ffba_engine #(
        .HEAP_BYTES   (HEAP_BYTES),
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .MIN_SPLIT    (MIN_SPLIT)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .heap_limit (heap_limit_reg),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_cmd      (q_cmd),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );
endmodule

[sim/first_fit_block_allocator_unit_tb.sv]
// Testbench for the first-fit block allocator: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module first_fit_block_allocator_unit_tb;
    import ffba_pkg::*;

    localparam int HEAP_BYTES   = 65536;
    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 16;
    localparam int MIN_SPLIT    = 64;
    // Idle time after the queues empty, with a margin over the slowest item.
    localparam int DRAIN_CYCLES = 8 * MAX_BLOCKS;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_we = 1'b0;
    logic [16:0] cfg_wdata = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    ffba_req_t s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    ffba_rsp_t m_data;

    first_fit_block_allocator_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    // Predictor state: a private copy of the block table and the limit register.
    logic [16:0] heap_limit_q;
    logic [16:0] tbl_start [MAX_BLOCKS];
    logic [16:0] tbl_bytes [MAX_BLOCKS];
    logic        tbl_free  [MAX_BLOCKS];
    int          tbl_count;
    logic [16:0] top_q;

    ffba_req_t pending_reqs[$];   // transactions waiting to be offered
    ffba_rsp_t expected_rsps[$];  // predicted results, oldest first
    logic [15:0] live_addrs[$];   // granted addresses not yet released

    int  n_errors = 0;
    int  n_results = 0;
    int  n_allocs_ok = 0;
    int  n_merges = 0;
    bit  idling_on = 1'b1;
    int  rx_hold = 0;       // long receiver hold-off, counted by the monitor

    // Remove entry idx by shifting the tail down.
    function automatic void table_remove(input int idx);
        for (int k = idx; k + 1 < tbl_count; k++) begin
            tbl_start[k] = tbl_start[k+1];
            tbl_bytes[k] = tbl_bytes[k+1];
            tbl_free[k]  = tbl_free[k+1];
        end
        tbl_count--;
    endfunction

    // Insert an entry at idx, shifting the tail up; caller guarantees room.
    function automatic void table_insert(input int idx, input logic [16:0] st,
                                         input logic [16:0] nb, input logic fr);
        for (int k = tbl_count; k > idx; k--) begin
            tbl_start[k] = tbl_start[k-1];
            tbl_bytes[k] = tbl_bytes[k-1];
            tbl_free[k]  = tbl_free[k-1];
        end
        tbl_start[idx] = st;
        tbl_bytes[idx] = nb;
        tbl_free[idx]  = fr;
        tbl_count++;
    endfunction

    // Works out the allocator's answer to one request and updates the table.
    function automatic ffba_rsp_t allocator_answer(input ffba_req_t rq);
        ffba_rsp_t r;
        logic [17:0] rounded;
        logic [17:0] need;
        logic [17:0] lim;
        int hit;
        r.grant_addr = '0;
        r.status = ST_OK;
        if (rq.req_type == REQ_ALLOC) begin
            rounded = ({1'b0, rq.req_size} + 18'd7) & ~18'd7;
            hit = -1;
            if (rq.req_size == 0) begin
                r.status = ST_ZERO;
                return r;
            end
            for (int i = 0; i < tbl_count; i++) begin
                if (hit < 0 && tbl_free[i] && tbl_bytes[i] >= rounded) hit = i;
            end
            if (hit >= 0) begin
                if (tbl_bytes[hit] >= rounded + HEADER_BYTES + MIN_SPLIT &&
                        tbl_count < MAX_BLOCKS) begin
                    table_insert(hit + 1, 17'(tbl_start[hit] + HEADER_BYTES + rounded),
                                 17'(tbl_bytes[hit] - rounded - HEADER_BYTES), 1'b1);
                    tbl_bytes[hit] = 17'(rounded);
                end
                tbl_free[hit] = 1'b0;
                r.grant_addr = 16'(tbl_start[hit] + HEADER_BYTES);
                n_allocs_ok++;
                return r;
            end
            lim = (heap_limit_q > HEAP_BYTES) ? 18'(HEAP_BYTES) : {1'b0, heap_limit_q};
            need = 18'(top_q + HEADER_BYTES + rounded);
            if (tbl_count >= MAX_BLOCKS || need > lim) begin
                r.status = ST_NOSPACE;
                return r;
            end
            table_insert(tbl_count, top_q, 17'(rounded), 1'b0);
            r.grant_addr = 16'(top_q + HEADER_BYTES);
            top_q = 17'(need);
            n_allocs_ok++;
        end else begin
            hit = -1;
            if (rq.release_addr == 0) begin
                r.status = ST_NULL;
                return r;
            end
            for (int i = 0; i < tbl_count; i++) begin
                if (hit < 0 && 16'(tbl_start[i] + HEADER_BYTES) == rq.release_addr) hit = i;
            end
            if (hit < 0 || tbl_free[hit]) begin
                r.status = ST_UNKNOWN;
                return r;
            end
            tbl_free[hit] = 1'b1;
            if (hit + 1 < tbl_count && tbl_free[hit+1]) begin
                tbl_bytes[hit] = 17'(tbl_bytes[hit] + HEADER_BYTES + tbl_bytes[hit+1]);
                table_remove(hit + 1);
                n_merges++;
            end
            if (hit > 0 && tbl_free[hit-1]) begin
                tbl_bytes[hit-1] = 17'(tbl_bytes[hit-1] + HEADER_BYTES + tbl_bytes[hit]);
                table_remove(hit);
                n_merges++;
            end
        end
        return r;
    endfunction

    // Driver: offers the head of the pending queue, holding it until accepted.
    int tx_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_rsps.push_back(allocator_answer(s_data));
                void'(pending_reqs.pop_front());
            end
            if (s_valid && !s_ready) begin
                // Payload held until the transaction is taken.
            end else if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                if (idling_on && $urandom_range(0, 7) == 0) begin
                    tx_gap <= $urandom_range(1, 10) - 1;
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_data  <= pending_reqs[0];
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each result transaction and makes the ready pattern.
    int rx_gap = 0;
    always @(posedge aclk) begin
        ffba_rsp_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected result addr=%h status=%0d", $time,
                             m_data.grant_addr, m_data.status);
                    n_errors++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (want.grant_addr !== m_data.grant_addr) begin
                        $display("%0t: grant_addr mismatch expected %h actual %h",
                                 $time, want.grant_addr, m_data.grant_addr);
                        n_errors++;
                    end
                    if (want.status !== m_data.status) begin
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, want.status, m_data.status);
                        n_errors++;
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                m_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                rx_gap <= $urandom_range(1, 10) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_alloc(input logic [16:0] sz);
        ffba_req_t rq;
        rq = '0;
        rq.req_type = REQ_ALLOC;
        rq.req_size = sz;
        rq.release_addr = 16'($urandom);
        pending_reqs.push_back(rq);
    endtask

    task automatic push_release(input logic [15:0] a);
        ffba_req_t rq;
        rq = '0;
        rq.req_type = REQ_RELEASE;
        rq.req_size = 17'($urandom);
        rq.release_addr = a;
        pending_reqs.push_back(rq);
    endtask

    // Waits until every queued transaction has been taken and answered.
    task automatic wait_quiet();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || s_valid)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register writes only happen while the block is idle.
    task automatic set_limit(input logic [16:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        heap_limit_q = v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Random sizes: mostly small so the table churns, a few at the extremes.
    function automatic logic [16:0] pick_size();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 3) return 17'($urandom_range(0, 131071));
        if (sel < 6) return 17'($urandom_range(0, 1));
        if (sel < 20) return 17'($urandom_range(1, 4096));
        return 17'($urandom_range(1, 600));
    endfunction

    // Stimulus runs on the driver's own model of live addresses, which only
    // guides the mix; the predictor decides what is correct.
    task automatic random_phase(input int n, input int pressure);
        for (int i = 0; i < n; i++) begin
            int sel;
            sel = $urandom_range(0, 99);
            if (pressure == 1 && i == n / 2) begin
                while (pending_reqs.size() > 0) @(posedge aclk);
                rx_hold = 400;
                repeat (20) push_alloc(17'($urandom_range(1, 64)));
            end
            if (sel < 50) begin
                push_alloc(pick_size());
            end else if (sel < 92) begin
                push_release(16'($urandom_range(1, 65535)) & 16'hfff0);
            end else if (sel < 96) begin
                push_release('0);
            end else begin
                push_release(16'($urandom));
            end
        end
    endtask

    // The releases above are rarely valid; refresh them with real grants.
    always @(posedge aclk) begin
        if (m_valid && m_ready && m_data.status == ST_OK && m_data.grant_addr != 0)
            live_addrs.push_back(m_data.grant_addr);
    end

    task automatic live_phase(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 0 || live_addrs.size() == 0) begin
                push_alloc(pick_size());
            end else begin
                int j;
                j = $urandom_range(0, live_addrs.size() - 1);
                push_release(live_addrs[j]);
                live_addrs.delete(j);
            end
            while (pending_reqs.size() > 8) @(posedge aclk);
        end
    endtask

    initial begin
        heap_limit_q = 17'd65536;
        tbl_count = 0;
        top_q = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: extremes, both operations and every special case.
        set_limit(17'h1ffff);
        push_alloc(17'd0);
        push_alloc(17'd1);
        push_alloc(17'd8);
        push_alloc(17'd200);
        push_alloc(17'd24);
        push_release(16'd0);
        push_release(16'hffff);
        push_release(16'd16);
        push_release(16'd16);
        push_release(16'd56);
        push_release(16'd40);
        push_alloc(17'd8);
        push_alloc(17'd131071);
        push_alloc(17'd65536);
        push_alloc(17'd65000);
        push_alloc(17'd40);
        wait_quiet();

        // Sender pauses until every expected result has come, then a tight limit.
        set_limit(17'd0);
        push_alloc(17'd1);
        wait_quiet();
        set_limit(17'd4096);
        live_phase(500);
        wait_quiet();

        // Fill the table past its 64 entries with tiny blocks.
        set_limit(17'd65536);
        repeat (70) push_alloc(17'd8);
        live_phase(400);
        random_phase(300, 1);
        wait_quiet();

        set_limit(17'd65535);
        live_phase(250);
        wait_quiet();
        idling_on = 1'b0;
        set_limit(17'(HEAP_BYTES));
        live_phase(150);
        random_phase(60, 0);
        wait_quiet();

        $display("covered %0d results, %0d good allocations, %0d merges",
                 n_results, n_allocs_ok, n_merges);
        $display("limits tried: 0, 4096, 65535, 65536 and 131071");
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

endmodule
